// File: hdl/olar_pkg.sv
// Shared types, constants and microprogram for the ordered list block.
// Used by olar_seq and ordered_list_append_remove; depends on nothing else.
package olar_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;
    localparam int VALUE_W  = 32;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_step;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ACCEPT,
        C_FAIL_NOW,
        C_APPEND,
        C_HIT,
        C_SCAN_END,
        C_SHIFT_END,
        C_OUT_FREE
    } t_cond;

    typedef enum logic [3:0] {
        U_NOP,
        U_LATCH,
        U_FAIL,
        U_APPEND,
        U_STEP,
        U_MARK,
        U_MOVE,
        U_DEC_OK,
        U_EMIT
    } t_uop;

    // Three-way branch: first condition, then second, else fall through.
    typedef struct packed {
        t_cond cond_a;
        t_step tgt_a;
        t_uop  uop_a;
        t_cond cond_b;
        t_step tgt_b;
        t_uop  uop_b;
        t_step tgt_c;
        t_uop  uop_c;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic fail_now;
        logic append;
        logic hit;
        logic scan_end;
        logic shift_end;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic idle;
        t_uop uop;
    } t_ctrl;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{C_NEVER, ST_IDLE, U_NOP, C_NEVER, ST_IDLE, U_NOP, ST_IDLE, U_NOP};
        unique case (step)
            ST_IDLE:  w = '{C_ACCEPT,    ST_DISP,  U_LATCH,
                            C_NEVER,     ST_IDLE,  U_NOP,
                            ST_IDLE,     U_NOP};
            ST_DISP:  w = '{C_FAIL_NOW,  ST_DONE,  U_FAIL,
                            C_APPEND,    ST_DONE,  U_APPEND,
                            ST_SCAN,     U_STEP};
            ST_SCAN:  w = '{C_HIT,       ST_SHIFT, U_MARK,
                            C_SCAN_END,  ST_DONE,  U_FAIL,
                            ST_SCAN,     U_STEP};
            ST_SHIFT: w = '{C_SHIFT_END, ST_DONE,  U_DEC_OK,
                            C_NEVER,     ST_IDLE,  U_NOP,
                            ST_SHIFT,    U_MOVE};
            ST_DONE:  w = '{C_OUT_FREE,  ST_IDLE,  U_EMIT,
                            C_NEVER,     ST_IDLE,  U_NOP,
                            ST_DONE,     U_NOP};
            default:  w = '{C_NEVER, ST_IDLE, U_NOP, C_NEVER, ST_IDLE, U_NOP,
                            ST_IDLE, U_NOP};
        endcase
        return w;
    endfunction

    function automatic logic cond_true(input t_cond c, input t_status s);
        logic r;
        r = 1'b0;
        unique case (c)
            C_NEVER:     r = 1'b0;
            C_ACCEPT:    r = s.accept;
            C_FAIL_NOW:  r = s.fail_now;
            C_APPEND:    r = s.append;
            C_HIT:       r = s.hit;
            C_SCAN_END:  r = s.scan_end;
            C_SHIFT_END: r = s.shift_end;
            C_OUT_FREE:  r = s.out_free;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/olar_seq.sv
// Microcode sequencer: step register, control ROM lookup and branch select.
// Depends on olar_pkg for the microprogram and the status/control structs.
module olar_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  olar_pkg::t_status i_status,
    output olar_pkg::t_ctrl   o_ctrl
);

    olar_pkg::t_step  r_step;
    olar_pkg::t_step  n_step;
    olar_pkg::t_uword uw;
    logic             take_a;
    logic             take_b;

    assign uw     = olar_pkg::ucode(r_step);
    assign take_a = olar_pkg::cond_true(uw.cond_a, i_status);
    assign take_b = olar_pkg::cond_true(uw.cond_b, i_status);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= olar_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // next step
    always_comb begin
        priority if (take_a) begin
            n_step = uw.tgt_a;
        end else if (take_b) begin
            n_step = uw.tgt_b;
        end else begin
            n_step = uw.tgt_c;
        end
    end

    // control word to the datapath
    always_comb begin
        o_ctrl.idle = (r_step == olar_pkg::ST_IDLE);
        priority if (take_a) begin
            o_ctrl.uop = uw.uop_a;
        end else if (take_b) begin
            o_ctrl.uop = uw.uop_b;
        end else begin
            o_ctrl.uop = uw.uop_c;
        end
    end

endmodule

// File: hdl/ordered_list_append_remove.sv
// Ordered list of signed 32-bit values with append-at-tail and remove-first-match.
//
// Input channel: i_valid / o_stall carry one item (i_func, i_value). i_func selects
// append (value goes after the last entry) or remove (the entry nearest the head
// that equals value is deleted and later entries move up one place).
// Output channel: o_valid / i_stall carry one result per item: o_ok, o_count
// (entries held afterwards) and o_empty_res.
// Timing: an item is taken only while the sequencer sits in its idle step, one
// item at a time. An append or an empty/full fail goes straight to the done step.
// A remove reads one held entry per cycle until it hits, then moves each later
// entry up one place per cycle; a miss ends once every held entry has been read.
// A finished result sits in an output register, so the next item is accepted
// while it waits; if the receiver keeps i_stall high, the following result
// holds the sequencer in its done step until the register frees.
// Reset: synchronous, active low; the list comes up empty with no result pending.
// Entry RAM contents are not cleared; only entries below count are ever compared or moved.
module ordered_list_append_remove (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_func,
    input  logic signed [olar_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_ok,
    output logic [olar_pkg::COUNT_W-1:0]       o_count,
    output logic                               o_empty_res
);

    localparam int IDX_W = olar_pkg::IDX_W;
    localparam int CNT_W = olar_pkg::CNT_W;

    olar_pkg::t_status status;
    olar_pkg::t_ctrl   ctrl;

    logic [olar_pkg::VALUE_W-1:0] r_mem [olar_pkg::CAPACITY];
    logic [olar_pkg::VALUE_W-1:0] r_rdata;
    logic [olar_pkg::VALUE_W-1:0] r_value;
    logic                         r_func;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_ptr;
    logic [IDX_W-1:0]             r_wptr;
    logic                         r_ok;
    logic                         r_out_valid;
    logic                         r_out_ok;
    logic [olar_pkg::COUNT_W-1:0] r_out_count;
    logic                         r_out_empty;

    logic                         full;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [olar_pkg::VALUE_W-1:0] mem_wdata;

    olar_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    assign o_stall     = !ctrl.idle;
    assign o_valid     = r_out_valid;
    assign o_ok        = r_out_ok;
    assign o_count     = r_out_count;
    assign o_empty_res = r_out_empty;

    assign full = (r_count == CNT_W'(olar_pkg::CAPACITY));

    always_comb begin
        status.accept    = i_valid && ctrl.idle;
        status.fail_now  = ((r_func == olar_pkg::FUNC_APPEND) && full)
                        || ((r_func == olar_pkg::FUNC_REMOVE) && (r_count == '0));
        status.append    = (r_func == olar_pkg::FUNC_APPEND);
        status.hit       = (r_rdata == r_value);
        status.scan_end  = (r_ptr == r_count);
        status.shift_end = (({1'b0, r_wptr} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(r_count));
        status.out_free  = !r_out_valid || !i_stall;
    end

    // RAM write: tail on append, move-up during compaction
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_W-1:0];
        mem_wdata = r_value;
        if (ctrl.uop == olar_pkg::U_APPEND) begin
            mem_we = 1'b1;
        end else if (ctrl.uop == olar_pkg::U_MOVE) begin
            mem_we    = 1'b1;
            mem_waddr = r_wptr;
            mem_wdata = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_ptr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.uop == olar_pkg::U_APPEND) begin
                r_count <= r_count + CNT_W'(1);
            end else if (ctrl.uop == olar_pkg::U_DEC_OK) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (ctrl.uop == olar_pkg::U_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (ctrl.uop)
            olar_pkg::U_LATCH: begin
                r_func  <= i_func;
                r_value <= i_value;
                r_ptr   <= '0;
            end
            olar_pkg::U_FAIL: begin
                r_ok <= 1'b0;
            end
            olar_pkg::U_APPEND, olar_pkg::U_DEC_OK: begin
                r_ok <= 1'b1;
            end
            olar_pkg::U_STEP: begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            olar_pkg::U_MARK: begin
                // hit was the entry read last cycle
                r_wptr <= IDX_W'(r_ptr - CNT_W'(1));
                r_ptr  <= r_ptr + CNT_W'(1);
            end
            olar_pkg::U_MOVE: begin
                r_wptr <= r_wptr + IDX_W'(1);
                r_ptr  <= r_ptr + CNT_W'(1);
            end
            olar_pkg::U_EMIT: begin
                r_out_ok    <= r_ok;
                r_out_count <= olar_pkg::COUNT_W'(r_count);
                r_out_empty <= (r_count == '0);
            end
            default: begin
            end
        endcase
    end

endmodule
